// ===== sv/weighted_cosine_pair_score_unit_macros.svh =====
// Assertion macros used by the bound checker module wcps_checker.
`ifndef WEIGHTED_COSINE_PAIR_SCORE_UNIT_MACROS_SVH
`define WEIGHTED_COSINE_PAIR_SCORE_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define WCPS_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("weighted cosine pair score unit: assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define WCPS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("weighted cosine pair score unit: assertion failed");

`endif

// ===== sv/wcps_pkg.sv =====
package wcps_pkg;

   localparam int FEATURE_WIDTH_DEFAULT = 18;
   localparam int NUM_FEATURES = 5;
   localparam int WEIGHT_WIDTH = 16;
   localparam int THRESH_WIDTH = 18;
   localparam int SCORE_WIDTH = 20;
   localparam int SEARCH_STEPS = 17;
   localparam int CSR_INDEX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH = 18;

   localparam logic [WEIGHT_WIDTH-1:0] COSINE_WEIGHT_RESET = 16'd37356;
   localparam logic [WEIGHT_WIDTH-1:0] GENRE_WEIGHT_RESET = 16'd6554;
   localparam logic [WEIGHT_WIDTH-1:0] ARTIST_WEIGHT_RESET = 16'd21627;
   localparam logic [THRESH_WIDTH-1:0] EDGE_THRESHOLD_RESET = 18'd32768;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_COSINE_WEIGHT = 2'd0,
      CSR_GENRE_WEIGHT = 2'd1,
      CSR_ARTIST_WEIGHT = 2'd2,
      CSR_EDGE_THRESHOLD = 2'd3
   } csr_index_type;

endpackage

// ===== sv/wcps_if.sv =====
interface wcps_req_if import wcps_pkg::*; #(
   parameter int FEATURE_WIDTH = FEATURE_WIDTH_DEFAULT
);
   logic valid;
   logic ready;
   logic signed [FEATURE_WIDTH-1:0] a_loudness;
   logic signed [FEATURE_WIDTH-1:0] a_tempo;
   logic signed [FEATURE_WIDTH-1:0] a_energy;
   logic signed [FEATURE_WIDTH-1:0] a_acoustic;
   logic signed [FEATURE_WIDTH-1:0] a_dance;
   logic signed [FEATURE_WIDTH-1:0] b_loudness;
   logic signed [FEATURE_WIDTH-1:0] b_tempo;
   logic signed [FEATURE_WIDTH-1:0] b_energy;
   logic signed [FEATURE_WIDTH-1:0] b_acoustic;
   logic signed [FEATURE_WIDTH-1:0] b_dance;
   logic genre_match;
   logic artist_match;

   modport source (
      output valid, a_loudness, a_tempo, a_energy, a_acoustic, a_dance,
      output b_loudness, b_tempo, b_energy, b_acoustic, b_dance,
      output genre_match, artist_match,
      input ready
   );
   modport sink (
      input valid, a_loudness, a_tempo, a_energy, a_acoustic, a_dance,
      input b_loudness, b_tempo, b_energy, b_acoustic, b_dance,
      input genre_match, artist_match,
      output ready
   );
endinterface

interface wcps_rsp_if import wcps_pkg::*;;
   logic valid;
   logic ready;
   logic signed [SCORE_WIDTH-1:0] pair_score;
   logic add_edge;
   logic zero_norm;

   modport source (output valid, pair_score, add_edge, zero_norm, input ready);
   modport sink (input valid, pair_score, add_edge, zero_norm, output ready);
endinterface

// ===== sv/weighted_cosine_pair_score_unit.sv =====
// Channel   Direction  Payload
// req       in         ten signed features of items A and B, genre and artist match flags
// rsp       out        pair_score, add_edge, zero_norm
// csr       in         write enable, register index, write data
//
// One item enters per cycle while no result waits or rsp.ready is high.
// The pipeline has the 17 stages of the bit-by-bit cosine search after 6
// stages of products, sums and wide partial products, and 2 scoring stages.
// Reset clears all valid bits and loads the default weights and threshold.
// The whole pipeline holds while a result waits and rsp.ready is low.
module weighted_cosine_pair_score_unit import wcps_pkg::*; #(
   parameter int FEATURE_WIDTH = FEATURE_WIDTH_DEFAULT
) (
   input logic clock,
   input logic reset,
   wcps_req_if.sink req,
   wcps_rsp_if.source rsp,
   input logic csr_we,
   input logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input logic [CSR_DATA_WIDTH-1:0] csr_wdata
);

   localparam int MW = FEATURE_WIDTH;
   localparam int PW = 2 * MW;
   localparam int SW = PW + 1;
   localparam int HW = (SW + 1) / 2;
   localparam int LW = SW - HW;
   localparam int NW = 2 * SW;
   localparam int RW = NW + 34;
   localparam int KNW = NW + SEARCH_STEPS;
   localparam int MULW = WEIGHT_WIDTH + SEARCH_STEPS;

   typedef struct packed {
      logic [RW-1:0] rem;
      logic [NW-1:0] n;
      logic [KNW-1:0] kn;
      logic [SEARCH_STEPS-1:0] k;
      logic dneg;
      logic zero;
      logic genre;
      logic artist;
   } srch_type;

   logic adv;

   logic [WEIGHT_WIDTH-1:0] cos_w_ff, genre_w_ff, artist_w_ff;
   logic [THRESH_WIDTH-1:0] thresh_ff;

   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v7_ff, out_v_ff;
   logic [SEARCH_STEPS:0] srch_v_ff;

   logic signed [MW-1:0] fa_in [NUM_FEATURES];
   logic signed [MW-1:0] fb_in [NUM_FEATURES];
   logic signed [MW-1:0] fa_ff [NUM_FEATURES];
   logic signed [MW-1:0] fb_ff [NUM_FEATURES];
   logic [1:0] flags1_ff, flags2_ff, flags3_ff, flags4_ff, flags5_ff;

   logic [PW-1:0] p_in [NUM_FEATURES];
   logic [PW-1:0] qa_in [NUM_FEATURES];
   logic [PW-1:0] qb_in [NUM_FEATURES];
   logic [NUM_FEATURES-1:0] sgn_in;
   logic [PW-1:0] p_ff [NUM_FEATURES];
   logic [PW-1:0] qa_ff [NUM_FEATURES];
   logic [PW-1:0] qb_ff [NUM_FEATURES];
   logic [NUM_FEATURES-1:0] sgn_ff;

   logic [SW-1:0] pos_in, neg_in, sqa_in, sqb_in;
   logic [SW-1:0] pos_ff, neg_ff, sqa3_ff, sqb3_ff;

   logic [SW-1:0] d_in;
   logic dneg_in, zero_in;
   logic [SW-1:0] d_ff, sqa4_ff, sqb4_ff;
   logic dneg4_ff, zero4_ff, dneg5_ff, zero5_ff;

   logic [2*HW-1:0] dd_ll_in, dd_ll_ff, nn_ll_in, nn_ll_ff;
   logic [HW+LW-1:0] dd_lh_in, dd_lh_ff, nn_lh_in, nn_lh_ff, nn_hl_in, nn_hl_ff;
   logic [2*LW-1:0] dd_hh_in, dd_hh_ff, nn_hh_in, nn_hh_ff;

   srch_type srch_in [SEARCH_STEPS+1];
   srch_type srch_ff [SEARCH_STEPS+1];

   logic [MULW-1:0] mul_w;
   logic [SEARCH_STEPS-1:0] term_in, term_ff;
   logic dneg7_ff, zero7_ff;
   logic [1:0] flags7_ff;

   logic signed [SCORE_WIDTH:0] score_w;
   logic edge_in;
   logic signed [SCORE_WIDTH-1:0] score_in, score_ff;
   logic edge_ff, zero_ff;

   assign adv = !out_v_ff || rsp.ready;
   assign req.ready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         cos_w_ff <= COSINE_WEIGHT_RESET;
         genre_w_ff <= GENRE_WEIGHT_RESET;
         artist_w_ff <= ARTIST_WEIGHT_RESET;
         thresh_ff <= EDGE_THRESHOLD_RESET;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_COSINE_WEIGHT: cos_w_ff <= csr_wdata[WEIGHT_WIDTH-1:0];
            CSR_GENRE_WEIGHT: genre_w_ff <= csr_wdata[WEIGHT_WIDTH-1:0];
            CSR_ARTIST_WEIGHT: artist_w_ff <= csr_wdata[WEIGHT_WIDTH-1:0];
            CSR_EDGE_THRESHOLD: thresh_ff <= csr_wdata[THRESH_WIDTH-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         srch_v_ff <= '0;
         v7_ff <= 1'b0;
         out_v_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= req.valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
         srch_v_ff <= {srch_v_ff[SEARCH_STEPS-1:0], v5_ff};
         v7_ff <= srch_v_ff[SEARCH_STEPS];
         out_v_ff <= v7_ff;
      end
   end

   assign fa_in[0] = req.a_loudness;
   assign fa_in[1] = req.a_tempo;
   assign fa_in[2] = req.a_energy;
   assign fa_in[3] = req.a_acoustic;
   assign fa_in[4] = req.a_dance;
   assign fb_in[0] = req.b_loudness;
   assign fb_in[1] = req.b_tempo;
   assign fb_in[2] = req.b_energy;
   assign fb_in[3] = req.b_acoustic;
   assign fb_in[4] = req.b_dance;

   always_comb begin
      logic [MW-1:0] ma, mb;
      for (int i = 0; i < NUM_FEATURES; i++) begin
         ma = fa_ff[i][MW-1] ? MW'(-fa_ff[i]) : MW'(fa_ff[i]);
         mb = fb_ff[i][MW-1] ? MW'(-fb_ff[i]) : MW'(fb_ff[i]);
         p_in[i] = PW'(ma) * PW'(mb);
         qa_in[i] = PW'(ma) * PW'(ma);
         qb_in[i] = PW'(mb) * PW'(mb);
         sgn_in[i] = fa_ff[i][MW-1] ^ fb_ff[i][MW-1];
      end
   end

   always_comb begin
      pos_in = '0;
      neg_in = '0;
      sqa_in = '0;
      sqb_in = '0;
      for (int i = 0; i < NUM_FEATURES; i++) begin
         if (sgn_ff[i]) begin
            neg_in = neg_in + SW'(p_ff[i]);
         end else begin
            pos_in = pos_in + SW'(p_ff[i]);
         end
         sqa_in = sqa_in + SW'(qa_ff[i]);
         sqb_in = sqb_in + SW'(qb_ff[i]);
      end
   end

   always_comb begin
      zero_in = (sqa3_ff == '0) || (sqb3_ff == '0);
      dneg_in = pos_ff < neg_ff;
      d_in = dneg_in ? (neg_ff - pos_ff) : (pos_ff - neg_ff);
   end

   always_comb begin
      dd_ll_in = (2*HW)'(d_ff[HW-1:0]) * (2*HW)'(d_ff[HW-1:0]);
      dd_lh_in = (HW+LW)'(d_ff[HW-1:0]) * (HW+LW)'(d_ff[SW-1:HW]);
      dd_hh_in = (2*LW)'(d_ff[SW-1:HW]) * (2*LW)'(d_ff[SW-1:HW]);
      nn_ll_in = (2*HW)'(sqa4_ff[HW-1:0]) * (2*HW)'(sqb4_ff[HW-1:0]);
      nn_lh_in = (HW+LW)'(sqa4_ff[HW-1:0]) * (HW+LW)'(sqb4_ff[SW-1:HW]);
      nn_hl_in = (HW+LW)'(sqa4_ff[SW-1:HW]) * (HW+LW)'(sqb4_ff[HW-1:0]);
      nn_hh_in = (2*LW)'(sqa4_ff[SW-1:HW]) * (2*LW)'(sqb4_ff[SW-1:HW]);
   end

   always_comb begin
      logic [NW-1:0] dsq;
      dsq = (NW'(dd_hh_ff) << (2*HW)) + (NW'(dd_lh_ff) << (HW+1)) + NW'(dd_ll_ff);
      srch_in[0].rem = RW'(dsq) << 32;
      srch_in[0].n = (NW'(nn_hh_ff) << (2*HW)) + (NW'(nn_lh_ff) << HW)
         + (NW'(nn_hl_ff) << HW) + NW'(nn_ll_ff);
      srch_in[0].kn = '0;
      srch_in[0].k = '0;
      srch_in[0].dneg = dneg5_ff;
      srch_in[0].zero = zero5_ff;
      srch_in[0].genre = flags5_ff[1];
      srch_in[0].artist = flags5_ff[0];
   end

   // Each stage tries one bit of k, keeping rem = dot^2 * 2^32 - k^2 * N and kn = k * N.
   for (genvar g = 0; g < SEARCH_STEPS; g++) begin : g_srch
      localparam int B = SEARCH_STEPS - 1 - g;
      logic [RW-1:0] test;
      always_comb begin
         test = (RW'(srch_ff[g].kn) << (B + 1)) + (RW'(srch_ff[g].n) << (2 * B));
         srch_in[g+1] = srch_ff[g];
         if (test <= srch_ff[g].rem) begin
            srch_in[g+1].rem = srch_ff[g].rem - test;
            srch_in[g+1].kn = srch_ff[g].kn + (KNW'(srch_ff[g].n) << B);
            srch_in[g+1].k[B] = 1'b1;
         end
      end
   end

   assign mul_w = MULW'(cos_w_ff) * MULW'(srch_ff[SEARCH_STEPS].k);
   assign term_in = mul_w[WEIGHT_WIDTH +: SEARCH_STEPS];

   always_comb begin
      score_w = $signed((SCORE_WIDTH+1)'(term_ff));
      if (dneg7_ff) begin
         score_w = -score_w;
      end
      if (flags7_ff[1]) begin
         score_w = score_w + $signed((SCORE_WIDTH+1)'(genre_w_ff));
      end
      if (flags7_ff[0]) begin
         score_w = score_w + $signed((SCORE_WIDTH+1)'(artist_w_ff));
      end
      edge_in = !zero7_ff && (score_w >= $signed((SCORE_WIDTH+1)'(thresh_ff)));
      score_in = zero7_ff ? '0 : score_w[SCORE_WIDTH-1:0];
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         fa_ff <= fa_in;
         fb_ff <= fb_in;
         flags1_ff <= {req.genre_match, req.artist_match};
         p_ff <= p_in;
         qa_ff <= qa_in;
         qb_ff <= qb_in;
         sgn_ff <= sgn_in;
         flags2_ff <= flags1_ff;
         pos_ff <= pos_in;
         neg_ff <= neg_in;
         sqa3_ff <= sqa_in;
         sqb3_ff <= sqb_in;
         flags3_ff <= flags2_ff;
         d_ff <= d_in;
         dneg4_ff <= dneg_in;
         zero4_ff <= zero_in;
         sqa4_ff <= sqa3_ff;
         sqb4_ff <= sqb3_ff;
         flags4_ff <= flags3_ff;
         dd_ll_ff <= dd_ll_in;
         dd_lh_ff <= dd_lh_in;
         dd_hh_ff <= dd_hh_in;
         nn_ll_ff <= nn_ll_in;
         nn_lh_ff <= nn_lh_in;
         nn_hl_ff <= nn_hl_in;
         nn_hh_ff <= nn_hh_in;
         dneg5_ff <= dneg4_ff;
         zero5_ff <= zero4_ff;
         flags5_ff <= flags4_ff;
         for (int i = 0; i <= SEARCH_STEPS; i++) begin
            srch_ff[i] <= srch_in[i];
         end
         term_ff <= term_in;
         dneg7_ff <= srch_ff[SEARCH_STEPS].dneg;
         zero7_ff <= srch_ff[SEARCH_STEPS].zero;
         flags7_ff <= {srch_ff[SEARCH_STEPS].genre, srch_ff[SEARCH_STEPS].artist};
         score_ff <= score_in;
         edge_ff <= edge_in;
         zero_ff <= zero7_ff;
      end
   end

   assign rsp.valid = out_v_ff;
   assign rsp.pair_score = score_ff;
   assign rsp.add_edge = edge_ff;
   assign rsp.zero_norm = zero_ff;

endmodule

// ===== sv/wcps_checker.sv =====
`include "weighted_cosine_pair_score_unit_macros.svh"

module wcps_checker import wcps_pkg::*; (
   input logic clock,
   input logic reset,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic signed [SCORE_WIDTH-1:0] rsp_pair_score,
   input logic rsp_add_edge,
   input logic rsp_zero_norm
);

   `WCPS_ASSERT_IMPLY(a_zero_norm_clean, clock, reset, rsp_valid && rsp_zero_norm, rsp_pair_score == '0 && !rsp_add_edge)
   `WCPS_ASSERT_IMPLY(a_ready_follows_output, clock, reset, 1'b1, req_ready == (!rsp_valid || rsp_ready))
   `WCPS_ASSERT_IMPLY(a_empty_after_reset, clock, reset, $past(reset), !rsp_valid)
   `WCPS_ASSERT_NEXT(a_result_held, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_pair_score))

endmodule

bind weighted_cosine_pair_score_unit wcps_checker u_wcps_checker (
   .clock(clock),
   .reset(reset),
   .req_ready(req.ready),
   .rsp_valid(rsp.valid),
   .rsp_ready(rsp.ready),
   .rsp_pair_score(rsp.pair_score),
   .rsp_add_edge(rsp.add_edge),
   .rsp_zero_norm(rsp.zero_norm)
);

// ===== dv/weighted_cosine_pair_score_unit_checker.sv =====
module weighted_cosine_pair_score_unit_checker import wcps_pkg::*; (
   input logic clock,
   input logic reset,
   wcps_req_if req,
   wcps_rsp_if rsp,
   input logic csr_we,
   input logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input logic [CSR_DATA_WIDTH-1:0] csr_wdata,
   output int error_count,
   output int outstanding
);

   typedef struct packed {
      logic [SCORE_WIDTH-1:0] pair_score;
      logic add_edge;
      logic zero_norm;
   } score_result_type;

   logic [WEIGHT_WIDTH-1:0] cosine_weight;
   logic [WEIGHT_WIDTH-1:0] genre_weight;
   logic [WEIGHT_WIDTH-1:0] artist_weight;
   logic [THRESH_WIDTH-1:0] edge_threshold;
   score_result_type expected_scores[$];

   assign outstanding = expected_scores.size();

   function automatic score_result_type score_pair(input longint fa[NUM_FEATURES],
         input longint fb[NUM_FEATURES], input logic genre, input logic artist);
      score_result_type r;
      longint dot;
      longint sqa;
      longint sqb;
      longint dmag;
      longint term;
      longint score;
      logic [127:0] rhs;
      logic [127:0] norm2;
      logic [127:0] cand;
      longint k;
      dot = 0;
      sqa = 0;
      sqb = 0;
      for (int i = 0; i < NUM_FEATURES; i++) begin
         dot += fa[i] * fb[i];
         sqa += fa[i] * fa[i];
         sqb += fb[i] * fb[i];
      end
      if (sqa == 0 || sqb == 0) begin
         r.pair_score = '0;
         r.add_edge = 1'b0;
         r.zero_norm = 1'b1;
         return r;
      end
      dmag = (dot < 0) ? -dot : dot;
      rhs = (128'(dmag) * 128'(dmag)) << 32;
      norm2 = 128'(sqa) * 128'(sqb);
      k = 0;
      for (int b = 16; b >= 0; b--) begin
         cand = 128'(k | (longint'(1) << b));
         if (cand * cand * norm2 <= rhs) k = k | (longint'(1) << b);
      end
      term = (longint'(cosine_weight) * k) >>> 16;
      score = (dot < 0) ? -term : term;
      if (genre) score += longint'(genre_weight);
      if (artist) score += longint'(artist_weight);
      r.pair_score = score[SCORE_WIDTH-1:0];
      r.add_edge = (score >= longint'(edge_threshold));
      r.zero_norm = 1'b0;
      return r;
   endfunction

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
      error_count++;
   endtask

   initial error_count = 0;

   always @(posedge clock) begin
      longint fa[NUM_FEATURES];
      longint fb[NUM_FEATURES];
      score_result_type want;
      if (reset) begin
         cosine_weight = COSINE_WEIGHT_RESET;
         genre_weight = GENRE_WEIGHT_RESET;
         artist_weight = ARTIST_WEIGHT_RESET;
         edge_threshold = EDGE_THRESHOLD_RESET;
         expected_scores.delete();
      end else begin
         if (csr_we) begin
            case (csr_index_type'(csr_index))
               CSR_COSINE_WEIGHT: cosine_weight = csr_wdata[WEIGHT_WIDTH-1:0];
               CSR_GENRE_WEIGHT: genre_weight = csr_wdata[WEIGHT_WIDTH-1:0];
               CSR_ARTIST_WEIGHT: artist_weight = csr_wdata[WEIGHT_WIDTH-1:0];
               CSR_EDGE_THRESHOLD: edge_threshold = csr_wdata[THRESH_WIDTH-1:0];
               default: ;
            endcase
         end
         if (rsp.valid && rsp.ready) begin
            if (expected_scores.size() == 0) begin
               report_mismatch("unexpected item, pair_score",
                  longint'($signed(rsp.pair_score)), longint'(0));
            end else begin
               want = expected_scores.pop_front();
               if (rsp.pair_score !== want.pair_score)
                  report_mismatch("pair_score", longint'($signed(rsp.pair_score)),
                     longint'($signed(want.pair_score)));
               if (rsp.add_edge !== want.add_edge)
                  report_mismatch("add_edge", longint'(rsp.add_edge),
                     longint'(want.add_edge));
               if (rsp.zero_norm !== want.zero_norm)
                  report_mismatch("zero_norm", longint'(rsp.zero_norm),
                     longint'(want.zero_norm));
            end
         end
         if (req.valid && req.ready) begin
            fa[0] = longint'(req.a_loudness);
            fa[1] = longint'(req.a_tempo);
            fa[2] = longint'(req.a_energy);
            fa[3] = longint'(req.a_acoustic);
            fa[4] = longint'(req.a_dance);
            fb[0] = longint'(req.b_loudness);
            fb[1] = longint'(req.b_tempo);
            fb[2] = longint'(req.b_energy);
            fb[3] = longint'(req.b_acoustic);
            fb[4] = longint'(req.b_dance);
            expected_scores.insert(expected_scores.size(),
               score_pair(fa, fb, req.genre_match, req.artist_match));
         end
      end
   end

endmodule

// ===== dv/weighted_cosine_pair_score_unit_test.sv =====
module weighted_cosine_pair_score_unit_test;
   import wcps_pkg::*;

   localparam int FW = FEATURE_WIDTH_DEFAULT;
   localparam longint FMAX = (longint'(1) << (FW - 1)) - 1;
   localparam longint FMIN = -(longint'(1) << (FW - 1));
   localparam int STALL_LIMIT = 5000;

   typedef longint feat_vec_type[NUM_FEATURES];

   logic clock;
   logic reset;
   logic csr_we;
   logic [CSR_INDEX_WIDTH-1:0] csr_index;
   logic [CSR_DATA_WIDTH-1:0] csr_wdata;
   int error_count;
   int outstanding;
   int send_idle_pct;
   int recv_stall_pct;
   int hold_cycles;
   int quiet_cycles;

   wcps_req_if #(.FEATURE_WIDTH(FW)) req ();
   wcps_rsp_if rsp ();

   weighted_cosine_pair_score_unit #(.FEATURE_WIDTH(FW)) dut (
      .clock(clock), .reset(reset), .req(req), .rsp(rsp),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   weighted_cosine_pair_score_unit_checker checker_inst (
      .clock(clock), .reset(reset), .req(req), .rsp(rsp),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .error_count(error_count), .outstanding(outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      rsp.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_cycles > 0) begin
            rsp.ready <= 1'b0;
            hold_cycles--;
         end else begin
            rsp.ready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic write_reg(input csr_index_type idx, input int value);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= CSR_DATA_WIDTH'(value);
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic send_pair(input feat_vec_type fa, input feat_vec_type fb,
         input logic genre, input logic artist);
      req.valid <= 1'b1;
      req.a_loudness <= FW'(fa[0]);
      req.a_tempo <= FW'(fa[1]);
      req.a_energy <= FW'(fa[2]);
      req.a_acoustic <= FW'(fa[3]);
      req.a_dance <= FW'(fa[4]);
      req.b_loudness <= FW'(fb[0]);
      req.b_tempo <= FW'(fb[1]);
      req.b_energy <= FW'(fb[2]);
      req.b_acoustic <= FW'(fb[3]);
      req.b_dance <= FW'(fb[4]);
      req.genre_match <= genre;
      req.artist_match <= artist;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      if ($urandom_range(99) < send_idle_pct) begin
         req.valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < send_idle_pct) @(posedge clock);
      end
   endtask

   task automatic drain();
      req.valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (30) @(posedge clock);
   endtask

   function automatic longint random_feature(input int kind);
      case (kind)
         0: return FMIN + longint'($urandom_range(2 ** FW - 1));
         1: return longint'($urandom_range(1024)) - 512;
         default: begin
            case ($urandom_range(3))
               0: return FMAX;
               1: return FMIN;
               2: return 0;
               default: return longint'($urandom_range(2)) - 1;
            endcase
         end
      endcase
   endfunction

   task automatic send_random_pair();
      feat_vec_type fa;
      feat_vec_type fb;
      int kind;
      longint v;
      kind = $urandom_range(9);
      for (int i = 0; i < NUM_FEATURES; i++) begin
         fa[i] = random_feature(kind < 4 ? 0 : (kind < 6 ? 1 : 2));
         fb[i] = random_feature(kind < 4 ? 0 : (kind < 6 ? 1 : 2));
      end
      if (kind == 8 || kind == 3) begin
         for (int i = 0; i < NUM_FEATURES; i++) begin
            v = fa[i] + longint'($urandom_range(64)) - 32;
            if ($urandom_range(1)) v = -v;
            fb[i] = (v > FMAX) ? FMAX : ((v < FMIN) ? FMIN : v);
         end
      end
      if (kind == 9) begin
         for (int i = 0; i < NUM_FEATURES; i++) begin
            if ($urandom_range(1)) fa[i] = 0;
            else fb[i] = 0;
         end
         if ($urandom_range(1)) fa = '{0, 0, 0, 0, 0};
         else fb = '{0, 0, 0, 0, 0};
      end
      send_pair(fa, fb, 1'($urandom_range(1)), 1'($urandom_range(1)));
   endtask

   task automatic send_directed();
      feat_vec_type zero_vec;
      feat_vec_type max_vec;
      feat_vec_type min_vec;
      feat_vec_type one_hot;
      feat_vec_type other_hot;
      zero_vec = '{0, 0, 0, 0, 0};
      max_vec = '{FMAX, FMAX, FMAX, FMAX, FMAX};
      min_vec = '{FMIN, FMIN, FMIN, FMIN, FMIN};
      send_pair(zero_vec, max_vec, 1'b1, 1'b1);
      send_pair(min_vec, zero_vec, 1'b1, 1'b0);
      send_pair(zero_vec, zero_vec, 1'b0, 1'b1);
      send_pair(max_vec, max_vec, 1'b0, 1'b0);
      send_pair(min_vec, min_vec, 1'b1, 1'b1);
      send_pair(max_vec, min_vec, 1'b0, 1'b0);
      send_pair(min_vec, max_vec, 1'b1, 1'b1);
      for (int i = 0; i < NUM_FEATURES; i++) begin
         one_hot = zero_vec;
         other_hot = zero_vec;
         one_hot[i] = (i % 2) ? FMIN : 1;
         other_hot[(i + 1) % NUM_FEATURES] = FMAX;
         send_pair(one_hot, other_hot, i[0], i[1]);
         send_pair(one_hot, one_hot, i[1], i[0]);
      end
      for (int g = 0; g < 4; g++) begin
         send_pair('{1, -1, 1, -1, 1}, '{1, -1, 1, -1, 1}, g[0], g[1]);
      end
      send_pair('{FMAX, 0, 0, 0, 0}, '{FMAX, 1, 0, 0, 0}, 1'b0, 1'b0);
      send_pair('{-1, -1, -1, -1, -1}, '{1, 1, 1, 1, 1}, 1'b1, 1'b1);
   endtask

   task automatic run_phase(input int cw, input int gw, input int aw, input int thr,
         input int idle_pct, input int stall_pct, input int count);
      write_reg(CSR_COSINE_WEIGHT, cw);
      write_reg(CSR_GENRE_WEIGHT, gw);
      write_reg(CSR_ARTIST_WEIGHT, aw);
      write_reg(CSR_EDGE_THRESHOLD, thr);
      send_idle_pct = idle_pct;
      recv_stall_pct = stall_pct;
      for (int n = 0; n < count; n++) send_random_pair();
      drain();
   endtask

   initial begin
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      hold_cycles = 0;
      quiet_cycles = 0;
      req.valid = 1'b0;
      req.a_loudness = '0;
      req.a_tempo = '0;
      req.a_energy = '0;
      req.a_acoustic = '0;
      req.a_dance = '0;
      req.b_loudness = '0;
      req.b_tempo = '0;
      req.b_energy = '0;
      req.b_acoustic = '0;
      req.b_dance = '0;
      req.genre_match = 1'b0;
      req.artist_match = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_directed();
      for (int n = 0; n < 250; n++) send_random_pair();
      drain();

      run_phase(0, 0, 0, 0, 83, 0, 300);
      run_phase(65535, 65535, 65535, 196607, 0, 83, 300);
      run_phase($urandom_range(65535), $urandom_range(65535), $urandom_range(65535),
         $urandom_range(196607), 29, 29, 300);

      write_reg(CSR_GENRE_WEIGHT, 0);
      send_idle_pct = 0;
      recv_stall_pct = 0;
      hold_cycles = 400;
      for (int n = 0; n < 150; n++) send_random_pair();
      req.valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      for (int n = 0; n < 150; n++) send_random_pair();
      drain();

      run_phase($urandom_range(65535), $urandom_range(65535), $urandom_range(65535),
         $urandom_range(65536), 29, 29, 300);

      if (error_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
